// File: rtl/sha256_pkg.sv
// ----------------------------------------------------------------------------
// sha256_pkg
// Round constants and initial hash values for the SHA-256 engine.
// ----------------------------------------------------------------------------
package sha256_pkg;

  localparam int unsigned WordW   = 32;
  localparam int unsigned NumWords = 8;
  localparam int unsigned WinDepth = 16;
  localparam int unsigned MsgW    = 61;

  localparam logic [7:0] PadMarker = 8'h80;
  localparam logic [5:0] LenStart  = 6'd56;
  localparam logic [5:0] LastPos   = 6'd63;

  typedef logic [WordW-1:0] word_t;

  localparam word_t HInit [NumWords] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  function automatic word_t round_k(input logic [5:0] idx);
    word_t k;
    unique case (idx)
      6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
      6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
      6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
      6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
      6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
      6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
      6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
      6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
      6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
      6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
      6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
      6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
      6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
      6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
      6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
      6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
      6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
      6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
      6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
      6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
      6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
      6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
      6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
      default: k = '0;
    endcase
    return k;
  endfunction

endpackage

// File: rtl/sha256_hash_engine_unit.sv
// ----------------------------------------------------------------------------
// sha256_hash_engine_unit - streaming SHA-256 engine
// Absorbed bytes fill the block buffer; the 64th byte of a block starts
// 64 rounds and then the chaining add (one round unit, one round a cycle).
// Finish writes padding one byte per cycle (9 to 72 bytes), runs one or two
// compressions, then offers 8 digest words, one per cycle of out_ready_i.
// Reset is asynchronous: control clears and the chaining state loads the IV.
// ----------------------------------------------------------------------------
module sha256_hash_engine_unit
  import sha256_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        command_i,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] digest_word_o,
  output logic [2:0]  word_index_o,
  output logic        last_word_o
);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StPad  = 3'd1;
  localparam logic [2:0] StRun  = 3'd2;
  localparam logic [2:0] StAdd  = 3'd3;
  localparam logic [2:0] StOut  = 3'd4;

  function automatic word_t rotr(input word_t x, input int unsigned n);
    return (x >> n) | (x << (WordW - n));
  endfunction

  logic [2:0]      state_q, state_d;
  logic [5:0]      fill_q, fill_d;
  logic [5:0]      rnd_q, rnd_d;
  logic [MsgW-1:0] msg_q, msg_d;
  logic            fin_q, fin_d;
  logic            first_q, first_d;
  logic            len_blk_q, len_blk_d;
  logic [2:0]      idx_q, idx_d;
  word_t           h_q [NumWords];
  word_t           h_d [NumWords];
  word_t           w_q [WinDepth];
  word_t           w_d [WinDepth];
  word_t           v_q [NumWords];
  word_t           v_d [NumWords];

  // byte shifter and round datapath
  logic            shift_en;
  logic [7:0]      shift_byte;
  logic [63:0]     len_bits;
  logic [5:0]      len_sel;
  word_t           big_s0, big_s1, ch, maj, t1, t2, sig0, sig1, w_next;

  assign len_bits = {msg_q, 3'b000};
  assign len_sel  = {3'(3'd7 - fill_q[2:0]), 3'b000};

  always_comb begin
    big_s1 = rotr(v_q[4], 6) ^ rotr(v_q[4], 11) ^ rotr(v_q[4], 25);
    ch     = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
    t1     = v_q[7] + big_s1 + ch + round_k(rnd_q) + w_q[0];
    big_s0 = rotr(v_q[0], 2) ^ rotr(v_q[0], 13) ^ rotr(v_q[0], 22);
    maj    = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
    t2     = big_s0 + maj;
    sig0   = rotr(w_q[1], 7) ^ rotr(w_q[1], 18) ^ (w_q[1] >> 3);
    sig1   = rotr(w_q[14], 17) ^ rotr(w_q[14], 19) ^ (w_q[14] >> 10);
    w_next = w_q[0] + sig0 + w_q[9] + sig1;
  end

  always_comb begin
    state_d   = state_q;
    fill_d    = fill_q;
    rnd_d     = rnd_q;
    msg_d     = msg_q;
    fin_d     = fin_q;
    first_d   = first_q;
    len_blk_d = len_blk_q;
    idx_d     = idx_q;
    h_d       = h_q;
    w_d       = w_q;
    v_d       = v_q;
    shift_en  = 1'b0;
    shift_byte = data_byte_i;

    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          if (!command_i) begin
            shift_en = 1'b1;
            fill_d   = fill_q + 6'd1;
            msg_d    = msg_q + MsgW'(1);
            if (fill_q == LastPos) begin
              state_d = StRun;
              v_d     = h_q;
              rnd_d   = '0;
            end
          end else begin
            fin_d   = 1'b1;
            first_d = 1'b1;
            state_d = StPad;
          end
        end
      end
      StPad: begin
        shift_en = 1'b1;
        if (first_q) begin
          shift_byte = PadMarker;
          len_blk_d  = (fill_q < LenStart);
        end else if (len_blk_q && fill_q >= LenStart) begin
          shift_byte = len_bits[len_sel +: 8];
        end else begin
          shift_byte = 8'h00;
        end
        first_d = 1'b0;
        fill_d  = fill_q + 6'd1;
        if (fill_q == LastPos) begin
          state_d = StRun;
          v_d     = h_q;
          rnd_d   = '0;
        end
      end
      StRun: begin
        for (int i = 0; i < WinDepth - 1; i++) begin
          w_d[i] = w_q[i+1];
        end
        w_d[WinDepth-1] = w_next;
        v_d[7] = v_q[6];
        v_d[6] = v_q[5];
        v_d[5] = v_q[4];
        v_d[4] = v_q[3] + t1;
        v_d[3] = v_q[2];
        v_d[2] = v_q[1];
        v_d[1] = v_q[0];
        v_d[0] = t1 + t2;
        rnd_d  = rnd_q + 6'd1;
        if (rnd_q == LastPos) begin
          state_d = StAdd;
        end
      end
      StAdd: begin
        for (int i = 0; i < NumWords; i++) begin
          h_d[i] = h_q[i] + v_q[i];
        end
        priority if (!fin_q) begin
          state_d = StIdle;
        end else if (len_blk_q) begin
          state_d = StOut;
          idx_d   = '0;
        end else begin
          // marker landed in the length field, length goes in a fresh block
          state_d   = StPad;
          len_blk_d = 1'b1;
        end
      end
      StOut: begin
        if (out_ready_i) begin
          idx_d = idx_q + 3'd1;
          if (idx_q == 3'd7) begin
            state_d = StIdle;
            h_d     = HInit;
            msg_d   = '0;
            fin_d   = 1'b0;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase

    if (shift_en) begin
      for (int i = 0; i < WinDepth - 1; i++) begin
        w_d[i] = {w_q[i][23:0], w_q[i+1][31:24]};
      end
      w_d[WinDepth-1] = {w_q[WinDepth-1][23:0], shift_byte};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      fill_q    <= '0;
      rnd_q     <= '0;
      msg_q     <= '0;
      fin_q     <= 1'b0;
      first_q   <= 1'b0;
      len_blk_q <= 1'b0;
      idx_q     <= '0;
      h_q       <= HInit;
    end else begin
      state_q   <= state_d;
      fill_q    <= fill_d;
      rnd_q     <= rnd_d;
      msg_q     <= msg_d;
      fin_q     <= fin_d;
      first_q   <= first_d;
      len_blk_q <= len_blk_d;
      idx_q     <= idx_d;
      h_q       <= h_d;
    end
  end

  always_ff @(posedge clk_i) begin
    w_q <= w_d;
    v_q <= v_d;
  end

  assign in_ready_o    = (state_q == StIdle);
  assign out_valid_o   = (state_q == StOut);
  assign digest_word_o = h_q[idx_q];
  assign word_index_o  = idx_q;
  assign last_word_o   = (idx_q == 3'd7);

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input and output offered together");

  a_run_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StRun) |-> (fill_q == '0))
    else $error("block buffer not empty during rounds");

  a_last_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && last_word_o) |=> (in_ready_o && msg_q == '0))
    else $error("engine not back to idle after final digest word");

  a_rounds_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StAdd) |-> (rnd_q == '0 && $past(state_q) == StRun))
    else $error("chaining add without a full round pass");

endmodule

// File: test/sha256_hash_engine_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sha256_hash_engine_unit_tb
// Streams byte messages into the SHA-256 engine with random gaps on both
// channels and checks every digest word against a behavioural SHA-256
// held in a small scoreboard. One long output stall backs the engine up.
// ----------------------------------------------------------------------------
module sha256_hash_engine_unit_tb;

  localparam bit CMD_ABSORB = 1'b0;
  localparam bit CMD_FINISH = 1'b1;

  localparam bit [31:0] IV_WORDS [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam bit [31:0] ROUND_CONST [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  word_idx;
    logic        is_last;
  } digest_word_t;

  class digest_scoreboard;
    bit [31:0]    chain [8];
    bit [7:0]     blk [64];
    bit [5:0]     fill;
    bit [60:0]    msg_len;
    digest_word_t digest_q [$];
    int unsigned  mismatches;
    int unsigned  inputs_seen;

    function new();
      mismatches  = 0;
      inputs_seen = 0;
      foreach (blk[i]) blk[i] = 8'h00;
      start_message();
    endfunction

    function void start_message();
      foreach (chain[i]) chain[i] = IV_WORDS[i];
      fill    = '0;
      msg_len = '0;
    endfunction

    function bit [31:0] ror(input bit [31:0] x, input int n);
      return (x >> n) | (x << (32 - n));
    endfunction

    function void compress();
      bit [31:0] w [16];
      bit [31:0] v [8];
      bit [31:0] wt, w15, w2, s0, s1, ch, mj, t1, t2;
      int t;
      foreach (v[i]) v[i] = chain[i];
      for (int r = 0; r < 64; r++) begin
        t = r % 16;
        if (r < 16) begin
          wt = {blk[4*t], blk[4*t+1], blk[4*t+2], blk[4*t+3]};
        end else begin
          w15 = w[(t + 1) % 16];
          w2  = w[(t + 14) % 16];
          s0  = ror(w15, 7) ^ ror(w15, 18) ^ (w15 >> 3);
          s1  = ror(w2, 17) ^ ror(w2, 19) ^ (w2 >> 10);
          wt  = w[t] + s0 + w[(t + 9) % 16] + s1;
        end
        w[t] = wt;
        s1 = ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25);
        ch = (v[4] & v[5]) ^ (~v[4] & v[6]);
        t1 = v[7] + s1 + ch + ROUND_CONST[r] + wt;
        s0 = ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22);
        mj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
        t2 = s0 + mj;
        v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
        v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
      end
      foreach (chain[i]) chain[i] += v[i];
    endfunction

    // called once per accepted input transaction
    function void note_input(input bit cmd, input bit [7:0] data);
      bit [63:0]    bit_len;
      int           pos;
      digest_word_t dw;
      inputs_seen++;
      if (cmd == CMD_ABSORB) begin
        blk[fill] = data;
        msg_len++;
        fill++;
        if (fill == 0) compress();
      end else begin
        // length in bits wraps modulo 2^64 along with the 61-bit byte count
        bit_len = {msg_len, 3'b000};
        blk[fill] = 8'h80;
        pos = int'(fill) + 1;
        if (pos > 56) begin
          while (pos < 64) begin
            blk[pos] = 8'h00;
            pos++;
          end
          compress();
          pos = 0;
        end
        while (pos < 56) begin
          blk[pos] = 8'h00;
          pos++;
        end
        for (int i = 0; i < 8; i++) blk[56+i] = bit_len[63-8*i -: 8];
        compress();
        for (int i = 0; i < 8; i++) begin
          dw.word     = chain[i];
          dw.word_idx = i[2:0];
          dw.is_last  = (i == 7);
          digest_q.push_back(dw);
        end
        start_message();
      end
    endfunction

    function void check_result(input logic [31:0] word, input logic [2:0] word_idx,
                               input logic is_last);
      digest_word_t dw;
      if (digest_q.size() == 0) begin
        $error("digest word %h with no digest pending", word);
        mismatches++;
        return;
      end
      dw = digest_q.pop_front();
      if (word !== dw.word) begin
        $error("digest_word: expected %h, got %h", dw.word, word);
        mismatches++;
      end
      if (word_idx !== dw.word_idx) begin
        $error("word_index: expected %0d, got %0d", dw.word_idx, word_idx);
        mismatches++;
      end
      if (is_last !== dw.is_last) begin
        $error("last_word: expected %b, got %b", dw.is_last, is_last);
        mismatches++;
      end
    endfunction

    function int unsigned words_pending();
      return digest_q.size();
    endfunction
  endclass

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        command   = 1'b0;
  logic [7:0]  data_byte = 8'h00;
  logic        out_ready = 1'b0;
  logic        in_ready;
  logic        out_valid;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  digest_scoreboard sb;

  sha256_hash_engine_unit uut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .command_i    (command),
    .data_byte_i  (data_byte),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .digest_word_o(digest_word),
    .word_index_o (word_index),
    .last_word_o  (last_word)
  );

  always #10 clk = ~clk;

  // mostly no gap, often a short one, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 96) return $urandom_range(1, 3);
    return $urandom_range(20, 60);
  endfunction

  task automatic push_item(input bit cmd, input logic [7:0] data);
    in_valid  <= 1'b1;
    command   <= cmd;
    data_byte <= data;
    do @(posedge clk); while (!in_ready);
    sb.note_input(cmd, data);
  endtask

  task automatic idle_input(input int unsigned cycles);
    if (cycles > 0) begin
      in_valid  <= 1'b0;
      command   <= 1'($urandom_range(0, 1));
      data_byte <= 8'($urandom_range(0, 255));
      repeat (cycles) @(posedge clk);
    end
  endtask

  task automatic send_message(input int unsigned len, input bit no_gaps);
    for (int unsigned i = 0; i < len; i++) begin
      push_item(CMD_ABSORB, 8'($urandom_range(0, 255)));
      if (!no_gaps) idle_input(pick_gap());
    end
    push_item(CMD_FINISH, 8'($urandom_range(0, 255)));
    if (!no_gaps) idle_input(pick_gap());
  endtask

  initial begin : drain_digest
    int unsigned pause_left;
    bit          held;
    pause_left = 0;
    held       = 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) sb.check_result(digest_word, word_index, last_word);
      // one long hold-off while a digest waits, so the input side stalls
      if (!held && out_valid && sb.inputs_seen >= 30) begin
        held       = 1'b1;
        pause_left = 400;
      end
      if (pause_left > 0) begin
        pause_left--;
        out_ready <= 1'b0;
      end else begin
        pause_left = pick_gap();
        out_ready <= (pause_left == 0);
      end
    end
  end

  initial begin : stimulus
    int unsigned len, r;
    bit          burst;
    sb = new();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty message twice, payload byte ignored on finish
    push_item(CMD_FINISH, 8'hff);
    push_item(CMD_FINISH, 8'h00);
    // "abc"
    push_item(CMD_ABSORB, 8'h61);
    push_item(CMD_ABSORB, 8'h62);
    push_item(CMD_ABSORB, 8'h63);
    push_item(CMD_FINISH, 8'h5a);
    idle_input(2);
    // byte extremes and a data byte equal to the pad marker
    push_item(CMD_ABSORB, 8'h00);
    push_item(CMD_ABSORB, 8'hff);
    push_item(CMD_ABSORB, 8'h80);
    push_item(CMD_ABSORB, 8'h7f);
    push_item(CMD_FINISH, 8'ha5);

    while (sb.inputs_seen < 260) begin
      r = $urandom_range(0, 99);
      if (r < 45) begin
        len = $urandom_range(0, 15);
      end else if (r < 75) begin
        // lengths around the one- and two-compression padding boundaries
        case ($urandom_range(0, 9))
          0: len = 54;
          1: len = 55;
          2: len = 56;
          3: len = 57;
          4: len = 62;
          5: len = 63;
          6: len = 64;
          7: len = 65;
          8: len = 119;
          default: len = 120;
        endcase
      end else begin
        len = $urandom_range(16, 130);
      end
      burst = ($urandom_range(0, 3) == 0);
      send_message(len, burst);
    end
    in_valid <= 1'b0;

    while (sb.words_pending() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin : watchdog
    #50_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
